// ===== hw/rtl/wsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfc_pkg
// Shared widths, wall codes, register indexes and the controller/datapath
// command and status types of the wall sensor filter.
// ----------------------------------------------------------------------------
package wsfc_pkg;

    localparam int DATA_W    = 12;
    localparam int PAT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // wall bits
    localparam logic [PAT_W-1:0] WALL_FRONT = 8'h88;
    localparam logic [PAT_W-1:0] WALL_RIGHT = 8'h44;
    localparam logic [PAT_W-1:0] WALL_LEFT  = 8'h11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_RIGHT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LEFT_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR        = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the input item, seed the accumulators
        logic accum;     // add oldest history entry, rotate history
        logic multiply;  // reciprocal multiply of the sums
        logic commit;    // shift history, load the output register
        logic use_avg;   // commit the average rather than the raw reading
    } wsfc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register can take a new item
    } wsfc_status_t;

endpackage

// ===== hw/rtl/wsfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsfc_ctrl
// Sequencer: accepts an item, steps the datapath through accumulation and
// division once the history is full, commits, and tracks the history fill count.
// ----------------------------------------------------------------------------
module wsfc_ctrl
    import wsfc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  wsfc_status_t status,
    output wsfc_cmd_t    cmd
);

    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HISTORY_DEPTH);
    localparam logic [CNT_W-1:0] LAST_C  = CNT_W'(HISTORY_DEPTH - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0] fill_reg,  fill_next;
    logic             fill_full;

    assign fill_full = (fill_reg == DEPTH_C);

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        fill_next    = fill_reg;
        cmd          = '0;
        s_ready      = (state_reg == ST_IDLE);
        cmd.capture  = s_valid && (state_reg == ST_IDLE);
        cmd.use_avg  = fill_full;
        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (s_valid) begin
                    state_next = fill_full ? ST_SUM : ST_DONE;
                end
            end
            ST_SUM: begin
                cmd.accum = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_C) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.multiply = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                    if (!fill_full) begin
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

// ===== hw/rtl/wsfc_datapath.sv =====
// ----------------------------------------------------------------------------
// wsfc_datapath
// History shift lines, running sums, reciprocal divider, threshold
// registers, wall classification and the output register.
// ----------------------------------------------------------------------------
module wsfc_datapath
    import wsfc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  wsfc_cmd_t            cmd,
    output wsfc_status_t         status,
    // configuration
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // input item
    input  logic [DATA_W-1:0]    s_front_right_reading,
    input  logic [DATA_W-1:0]    s_front_left_reading,
    input  logic [DATA_W-1:0]    s_left_reading,
    input  logic [DATA_W-1:0]    s_right_reading,
    // result item
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_left_filtered,
    output logic [DATA_W-1:0]    m_right_filtered,
    output logic [PAT_W-1:0]     m_wall_pattern,
    output logic                 m_filter_primed
);

    localparam int ACC_W  = DATA_W + $clog2(HISTORY_DEPTH + 1);
    localparam int RCP_W  = 32;
    localparam int PROD_W = ACC_W + RCP_W;
    // ceil(2^32 / (depth+1)): exact floor division for sums below 2^16
    localparam logic [63:0] DIVISOR = 64'(HISTORY_DEPTH + 1);
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RCP_W) + DIVISOR - 64'd1) / DIVISOR);

    logic [DATA_W-1:0] fr_reg, fl_reg, left_cur_reg, right_cur_reg;
    logic [ACC_W-1:0]  left_acc_reg, right_acc_reg;
    logic [PROD_W-1:0] left_prod_reg, right_prod_reg;
    logic [DATA_W-1:0] left_hist_reg  [HISTORY_DEPTH];
    logic [DATA_W-1:0] right_hist_reg [HISTORY_DEPTH];

    logic [DATA_W-1:0] fr_thr_reg, fl_thr_reg, r_thr_reg, l_thr_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_left_reg, m_right_reg;
    logic [PAT_W-1:0]  m_pattern_reg;
    logic              m_primed_reg;

    logic [DATA_W-1:0] left_new, right_new;
    logic [PAT_W-1:0]  pattern_next;

    assign status.out_free = !m_valid_reg || m_ready;

    // value committed to history and output
    assign left_new  = cmd.use_avg ? left_prod_reg[RCP_W +: DATA_W]  : left_cur_reg;
    assign right_new = cmd.use_avg ? right_prod_reg[RCP_W +: DATA_W] : right_cur_reg;

    // wall classification, strict compares
    always_comb begin
        pattern_next = '0;
        if ((fr_reg > fr_thr_reg) || (fl_reg > fl_thr_reg)) begin
            pattern_next = pattern_next | WALL_FRONT;
        end
        if (right_new > r_thr_reg) begin
            pattern_next = pattern_next | WALL_RIGHT;
        end
        if (left_new > l_thr_reg) begin
            pattern_next = pattern_next | WALL_LEFT;
        end
    end

    // threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_thr_reg <= '0;
            fl_thr_reg <= '0;
            r_thr_reg  <= '0;
            l_thr_reg  <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_FRONT_RIGHT_THR: fr_thr_reg <= cfg_data;
                CFG_FRONT_LEFT_THR:  fl_thr_reg <= cfg_data;
                CFG_RIGHT_THR:       r_thr_reg  <= cfg_data;
                CFG_LEFT_THR:        l_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture, accumulation and reciprocal multiply
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            fr_reg        <= s_front_right_reading;
            fl_reg        <= s_front_left_reading;
            left_cur_reg  <= s_left_reading;
            right_cur_reg <= s_right_reading;
            left_acc_reg  <= ACC_W'(s_left_reading);
            right_acc_reg <= ACC_W'(s_right_reading);
        end else if (cmd.accum) begin
            left_acc_reg  <= left_acc_reg  + ACC_W'(left_hist_reg[0]);
            right_acc_reg <= right_acc_reg + ACC_W'(right_hist_reg[0]);
        end
        if (cmd.multiply) begin
            left_prod_reg  <= PROD_W'(left_acc_reg)  * PROD_W'(RECIP);
            right_prod_reg <= PROD_W'(right_acc_reg) * PROD_W'(RECIP);
        end
    end

    // history lines: rotate while summing, shift in the new value on commit
    always_ff @(posedge aclk) begin
        if (cmd.accum || cmd.commit) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                left_hist_reg[i]  <= left_hist_reg[i+1];
                right_hist_reg[i] <= right_hist_reg[i+1];
            end
            if (cmd.accum) begin
                left_hist_reg[HISTORY_DEPTH-1]  <= left_hist_reg[0];
                right_hist_reg[HISTORY_DEPTH-1] <= right_hist_reg[0];
            end else begin
                left_hist_reg[HISTORY_DEPTH-1]  <= left_new;
                right_hist_reg[HISTORY_DEPTH-1] <= right_new;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.commit) begin
            m_left_reg    <= left_new;
            m_right_reg   <= right_new;
            m_pattern_reg <= pattern_next;
            m_primed_reg  <= cmd.use_avg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_left_filtered  = m_left_reg;
    assign m_right_filtered = m_right_reg;
    assign m_wall_pattern   = m_pattern_reg;
    assign m_filter_primed  = m_primed_reg;

endmodule

// ===== hw/rtl/wall_sensor_filter_and_classify_unit.sv =====
// An accepted item goes straight to commit while the history fills; once primed,
//   the sequencer first sums each history entry in turn and multiplies by the
//   reciprocal. Commit waits for a free output register, and a new item is taken
//   only after the previous one has been committed.
// Reset: synchronous, active low; clears sequencer, fill count, thresholds and
//   output valid. History contents are not cleared; the fill phase writes them.
// ----------------------------------------------------------------------------
// wall_sensor_filter_and_classify_unit
// Wall sensor moving-average filter with threshold wall classification.
// ----------------------------------------------------------------------------
module wall_sensor_filter_and_classify_unit
    import wsfc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_front_right_reading,
    input  logic [DATA_W-1:0]    s_front_left_reading,
    input  logic [DATA_W-1:0]    s_left_reading,
    input  logic [DATA_W-1:0]    s_right_reading,
    // result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_left_filtered,
    output logic [DATA_W-1:0]    m_right_filtered,
    output logic [PAT_W-1:0]     m_wall_pattern,
    output logic                 m_filter_primed
);

    wsfc_cmd_t    cmd;
    wsfc_status_t status;

    // registers always writable
    assign cfg_ready = 1'b1;

    wsfc_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wsfc_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .status                (status),
        .cfg_wr                (cfg_valid && cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_front_right_reading (s_front_right_reading),
        .s_front_left_reading  (s_front_left_reading),
        .s_left_reading        (s_left_reading),
        .s_right_reading       (s_right_reading),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_left_filtered       (m_left_filtered),
        .m_right_filtered      (m_right_filtered),
        .m_wall_pattern        (m_wall_pattern),
        .m_filter_primed       (m_filter_primed)
    );

endmodule

// ===== dv/wsfc_report_checker.sv =====
// ----------------------------------------------------------------------------
// wsfc_report_checker
// Watches the configuration, sample and report channels of the wall sensor
// filter, predicts each wall report from its own copy of the thresholds and
// side histories, and compares every accepted report with the oldest one due.
// ----------------------------------------------------------------------------
module wsfc_report_checker
    import wsfc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [DATA_W-1:0]    s_front_right_reading,
    input  logic [DATA_W-1:0]    s_front_left_reading,
    input  logic [DATA_W-1:0]    s_left_reading,
    input  logic [DATA_W-1:0]    s_right_reading,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [DATA_W-1:0]    m_left_filtered,
    input  logic [DATA_W-1:0]    m_right_filtered,
    input  logic [PAT_W-1:0]     m_wall_pattern,
    input  logic                 m_filter_primed,
    output int                   error_count,
    output int                   reports_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] left_filtered;
        logic [DATA_W-1:0] right_filtered;
        logic [PAT_W-1:0]  wall_pattern;
        logic              filter_primed;
    } wall_report_t;

    // shadow thresholds and side histories
    logic [DATA_W-1:0] thr_front_right;
    logic [DATA_W-1:0] thr_front_left;
    logic [DATA_W-1:0] thr_right;
    logic [DATA_W-1:0] thr_left;
    logic [DATA_W-1:0] left_hist  [HISTORY_DEPTH];
    logic [DATA_W-1:0] right_hist [HISTORY_DEPTH];
    int unsigned       fill_count;

    wall_report_t      awaited_reports [$];
    wall_report_t      due_report;

    initial begin
        error_count     = 0;
        reports_pending = 0;
    end

    // filter one sample set and classify the walls it shows
    function automatic wall_report_t classify_sample(
        input logic [DATA_W-1:0] front_right,
        input logic [DATA_W-1:0] front_left,
        input logic [DATA_W-1:0] left_raw,
        input logic [DATA_W-1:0] right_raw
    );
        wall_report_t rep;
        int unsigned  left_sum;
        int unsigned  right_sum;
        rep = '0;
        rep.left_filtered  = left_raw;
        rep.right_filtered = right_raw;
        if (fill_count < HISTORY_DEPTH) begin
            // fill phase: store and pass the raw side readings through
            left_hist[fill_count]  = left_raw;
            right_hist[fill_count] = right_raw;
            fill_count++;
        end else begin
            left_sum  = left_raw;
            right_sum = right_raw;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
                left_sum  += left_hist[i];
                right_sum += right_hist[i];
            end
            rep.left_filtered  = DATA_W'(left_sum / (HISTORY_DEPTH + 1));
            rep.right_filtered = DATA_W'(right_sum / (HISTORY_DEPTH + 1));
            rep.filter_primed  = 1'b1;
            // feedback: the average, not the raw reading, enters the history
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
                left_hist[i]  = left_hist[i+1];
                right_hist[i] = right_hist[i+1];
            end
            left_hist[HISTORY_DEPTH-1]  = rep.left_filtered;
            right_hist[HISTORY_DEPTH-1] = rep.right_filtered;
        end
        // strict comparisons
        if (front_right > thr_front_right || front_left > thr_front_left)
            rep.wall_pattern |= WALL_FRONT;
        if (rep.right_filtered > thr_right)
            rep.wall_pattern |= WALL_RIGHT;
        if (rep.left_filtered > thr_left)
            rep.wall_pattern |= WALL_LEFT;
        return rep;
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // channel monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            thr_front_right = '0;
            thr_front_left  = '0;
            thr_right       = '0;
            thr_left        = '0;
            fill_count      = 0;
            awaited_reports.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRONT_RIGHT_THR: thr_front_right = cfg_data;
                    CFG_FRONT_LEFT_THR:  thr_front_left  = cfg_data;
                    CFG_RIGHT_THR:       thr_right       = cfg_data;
                    CFG_LEFT_THR:        thr_left        = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("report accepted with none due: L=0x%0h R=0x%0h pat=0x%0h p=%0b",
                           m_left_filtered, m_right_filtered, m_wall_pattern,
                           m_filter_primed);
                    error_count++;
                end else begin
                    due_report = awaited_reports.pop_front();
                    check_field("left_filtered", due_report.left_filtered, m_left_filtered);
                    check_field("right_filtered", due_report.right_filtered,
                                m_right_filtered);
                    check_field("wall_pattern", due_report.wall_pattern, m_wall_pattern);
                    check_field("filter_primed", due_report.filter_primed,
                                m_filter_primed);
                end
            end
            if (s_valid && s_ready)
                awaited_reports.push_back(classify_sample(s_front_right_reading,
                                                          s_front_left_reading,
                                                          s_left_reading,
                                                          s_right_reading));
        end
        reports_pending <= awaited_reports.size();
    end

endmodule

// ===== dv/wall_sensor_filter_and_classify_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wall_sensor_filter_and_classify_unit_tb
// Drives sample sets and threshold writes into the wall sensor filter with
// random idling on both sides, a long report back-pressure and drain pauses;
// the report checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module wall_sensor_filter_and_classify_unit_tb;

    import wsfc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HISTORY_DEPTH = 4;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = 32;
    localparam int RAND_PHASES   = 13;
    localparam int PHASE_ITEMS   = 100;
    localparam logic [DATA_W-1:0] RD_MAX = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [DATA_W-1:0]    s_front_right_reading;
    logic [DATA_W-1:0]    s_front_left_reading;
    logic [DATA_W-1:0]    s_left_reading;
    logic [DATA_W-1:0]    s_right_reading;
    logic                 m_valid;
    logic                 m_ready;
    logic [DATA_W-1:0]    m_left_filtered;
    logic [DATA_W-1:0]    m_right_filtered;
    logic [PAT_W-1:0]     m_wall_pattern;
    logic                 m_filter_primed;

    int                   error_count;
    int                   reports_pending;
    int                   stall_cycles = 0;
    int                   hold_requests = 0;
    int                   holds_served = 0;
    bit                   no_idle = 1'b0;
    logic [DATA_W-1:0]    cur_thr [4];

    // clock
    always begin
        aclk = 1'b0;
        #(HALF_PERIOD);
        aclk = 1'b1;
        #(HALF_PERIOD);
    end

    wall_sensor_filter_and_classify_unit #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) DUT (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_front_right_reading (s_front_right_reading),
        .s_front_left_reading  (s_front_left_reading),
        .s_left_reading        (s_left_reading),
        .s_right_reading       (s_right_reading),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_left_filtered       (m_left_filtered),
        .m_right_filtered      (m_right_filtered),
        .m_wall_pattern        (m_wall_pattern),
        .m_filter_primed       (m_filter_primed)
    );

    wsfc_report_checker #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) report_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_front_right_reading (s_front_right_reading),
        .s_front_left_reading  (s_front_left_reading),
        .s_left_reading        (s_left_reading),
        .s_right_reading       (s_right_reading),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_left_filtered       (m_left_filtered),
        .m_right_filtered      (m_right_filtered),
        .m_wall_pattern        (m_wall_pattern),
        .m_filter_primed       (m_filter_primed),
        .error_count           (error_count),
        .reports_pending       (reports_pending)
    );

    // watchdog: cycles in which no channel moves an item
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        do @(posedge aclk); while (stall_cycles < STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // report receiver: random stalls, one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (holds_served < hold_requests) begin
                stall = LONG_HOLD;
                holds_served++;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // one register write; valid stays up for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        cur_thr[idx] = val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // only called with the block drained
    task automatic program_thresholds(input logic [DATA_W-1:0] fr, input logic [DATA_W-1:0] fl,
                                      input logic [DATA_W-1:0] rt, input logic [DATA_W-1:0] lt);
        write_reg(CFG_FRONT_RIGHT_THR, fr);
        write_reg(CFG_FRONT_LEFT_THR, fl);
        write_reg(CFG_RIGHT_THR, rt);
        write_reg(CFG_LEFT_THR, lt);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input logic [DATA_W-1:0] fr, input logic [DATA_W-1:0] fl,
                             input logic [DATA_W-1:0] lv, input logic [DATA_W-1:0] rv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid               <= 1'b1;
        s_front_right_reading <= fr;
        s_front_left_reading  <= fl;
        s_left_reading        <= lv;
        s_right_reading       <= rv;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering and wait for every due report
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (reports_pending != 0);
    endtask

    // extremes, values around the threshold, or anything
    function automatic logic [DATA_W-1:0] pick_reading(input logic [DATA_W-1:0] thr);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = int'(RD_MAX);
            2, 3, 4: v = int'(thr) + int'($urandom_range(0, 2)) - 1;
            default: v = int'($urandom_range(0, int'(RD_MAX)));
        endcase
        if (v < 0)
            v = 0;
        if (v > int'(RD_MAX))
            v = int'(RD_MAX);
        return v[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return RD_MAX;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        aresetn               = 1'b0;
        cfg_valid             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        s_valid               = 1'b0;
        s_front_right_reading = '0;
        s_front_left_reading  = '0;
        s_left_reading        = '0;
        s_right_reading       = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: fill phase with extremes and threshold edges
        program_thresholds(12'd2048, 12'd2048, 12'd2048, 12'd2048);
        send_item(12'h000, 12'hFFF, 12'hAAA, 12'h555);
        send_item(12'hFFF, 12'h000, 12'h555, 12'hAAA);
        send_item(12'd2048, 12'd2048, 12'd2048, 12'd2049);
        send_item(12'd2049, 12'd0, 12'd2049, 12'd2048);
        // primed: front wall from the front-left sensor alone, then rails
        send_item(12'd0, 12'd2049, 12'd2048, 12'd2048);
        repeat (3) send_item(RD_MAX, RD_MAX, RD_MAX, RD_MAX);
        repeat (3) send_item('0, '0, '0, '0);
        // top threshold never marks a wall
        wait_drained();
        program_thresholds(RD_MAX, RD_MAX, RD_MAX, RD_MAX);
        repeat (3) send_item(RD_MAX, RD_MAX, RD_MAX, RD_MAX);
        // zero threshold: any non-zero value marks a wall
        wait_drained();
        program_thresholds('0, '0, '0, '0);
        repeat (2) send_item('0, '0, '0, '0);
        repeat (2) send_item(12'd1, 12'd1, 12'd1, 12'd1);
        wait_drained();
        program_thresholds(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        send_item(12'h555, 12'hAAA, 12'hAAA, 12'h555);
        send_item(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        send_item(RD_MAX, '0, RD_MAX, '0);

        // random phases, each with its own threshold setting
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_drained();
            program_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                               pick_threshold());
            no_idle = (phase % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 3 && n == 40)
                    hold_requests++;
                if (phase == 6 && n == 50)
                    wait_drained();
                send_item(pick_reading(cur_thr[CFG_FRONT_RIGHT_THR]),
                          pick_reading(cur_thr[CFG_FRONT_LEFT_THR]),
                          pick_reading(cur_thr[CFG_LEFT_THR]),
                          pick_reading(cur_thr[CFG_RIGHT_THR]));
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0 && reports_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
